// File: rtl/firch_pkg.sv
// Shared types, constants and codes for the circular-history FIR filter.
package firch_pkg;

    localparam int SAMPLE_BITS  = 16;
    localparam int FRAC_BITS    = SAMPLE_BITS - 1;
    localparam int TAP_W        = 7;
    localparam int IDX_W        = 6;
    localparam int MAX_TAPS_DEF = 64;
    localparam int PADDR_W      = 3;
    localparam int APB_DW       = 32;

    localparam logic [PADDR_W-3:0] REG_TAP_COUNT = '0;

    typedef enum logic {
        OP_FILTER = 1'b0,
        OP_COEF   = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_WAIT
    } t_state;

    typedef struct packed {
        logic                          opcode;
        logic [IDX_W-1:0]              tap_index;
        logic signed [SAMPLE_BITS-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] filtered_sample;
        logic                          saturated;
    } t_out_item;

    typedef struct packed {
        logic acc_clr;
        logic mul_en;
        logic acc_en;
    } t_mac_ctl;

endpackage

// File: rtl/fir_filter_circular_history_core.sv
// Direct-form FIR filter over a circular sample history, top level and sequencer.
//
// Input channel (i_in_valid / o_in_stall / i_in_data) carries requests of two
// kinds. A coefficient request loads one tap in its accept cycle and gives no
// result. A sample request writes the sample into the history ring, then the
// shared multiply-accumulate unit walks the taps, one tap per cycle, reading
// one coefficient and one history entry each cycle from two RAMs.
// The result of a sample request follows the single MAC pass over the N taps
// (N = tap count), the RAM read and product registers and the accumulator.
// o_in_stall is high while a sample is being filtered, so the next sample
// is taken only once the last result has moved to the output register;
// coefficient requests go at one per cycle while idle.
// Output channel (o_out_valid / i_out_stall / o_out_data) has an output
// register: a finished result waits there while the next request is taken.
// If a second result finishes while the first is still stalled, the block
// holds it in the MAC and keeps o_in_stall high until the register frees.
// Reset clears history, coefficients (through valid bits), write position,
// and sets the tap count to the smaller of MAX_TAPS and 64. Writing the tap count over APB clears the
// history and the write position at once; coefficients are kept.
module fir_filter_circular_history_core #(
    parameter int MAX_TAPS = firch_pkg::MAX_TAPS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  firch_pkg::t_in_item              i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output firch_pkg::t_out_item             o_out_data,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [firch_pkg::PADDR_W-1:0]    paddr,
    input  logic [firch_pkg::APB_DW-1:0]     pwdata,
    output logic [firch_pkg::APB_DW-1:0]     prdata,
    output logic                             pready
);

    localparam int SB    = firch_pkg::SAMPLE_BITS;
    localparam int TW    = firch_pkg::TAP_W;
    localparam int AW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int CW    = (AW > TW) ? AW : TW;
    localparam int ACC_W = 2 * SB + AW;
    localparam int PW    = firch_pkg::PADDR_W;

    localparam logic [TW-1:0] TAP_RST = TW'((MAX_TAPS < 64) ? MAX_TAPS : 64);
    localparam logic [TW-1:0] TAP_MAX = (MAX_TAPS < (1 << TW)) ? TW'(MAX_TAPS) : '1;

    firch_pkg::t_state    r_state, n_state;
    firch_pkg::t_mac_ctl  w_ctl;
    firch_pkg::t_out_item r_out;

    logic [TW-1:0]       r_tap;
    logic [AW-1:0]       r_pos;
    logic [AW-1:0]       r_k;
    logic [AW-1:0]       r_h;
    logic [MAX_TAPS-1:0] r_hvalid;
    logic [MAX_TAPS-1:0] r_cvalid;
    logic                r_s1, r_s2;
    logic                r_hv1, r_cv1;
    logic                r_out_valid;

    logic          w_accept, w_smp_acc, w_coef_acc, w_coef_we;
    logic          w_rd_en, w_last, w_load, w_cfg_we;
    logic [TW-1:0] w_tap_m1;
    logic [TW-1:0] w_cfg_tap;
    logic [SB-1:0] w_hist_q, w_coef_q;
    logic signed [SB-1:0] w_samp, w_coef, w_q;
    logic          w_sat;

    assign w_accept   = i_in_valid && (r_state == firch_pkg::ST_IDLE);
    assign w_smp_acc  = w_accept && (i_in_data.opcode == firch_pkg::OP_FILTER);
    assign w_coef_acc = w_accept && (i_in_data.opcode == firch_pkg::OP_COEF);
    assign w_coef_we  = w_coef_acc && (int'(i_in_data.tap_index) < MAX_TAPS);
    assign w_tap_m1   = r_tap - TW'(1);
    assign w_last     = (CW'(r_k) == CW'(w_tap_m1));

    always_comb begin
        n_state = r_state;
        w_rd_en = 1'b0;
        w_load  = 1'b0;
        unique case (r_state)
            firch_pkg::ST_IDLE: begin
                if (w_smp_acc) begin
                    n_state = firch_pkg::ST_RUN;
                end
            end
            firch_pkg::ST_RUN: begin
                w_rd_en = 1'b1;
                if (w_last) begin
                    n_state = firch_pkg::ST_WAIT;
                end
            end
            firch_pkg::ST_WAIT: begin
                // drain the read and product registers, then hand off
                if (!r_s1 && !r_s2 && (!r_out_valid || !i_out_stall)) begin
                    w_load  = 1'b1;
                    n_state = firch_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = firch_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= firch_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // APB register: tap count, clamped to 1..MAX_TAPS
    assign pready   = 1'b1;
    assign w_cfg_we = psel && penable && pwrite
                      && (paddr[PW-1:2] == firch_pkg::REG_TAP_COUNT);

    always_comb begin
        w_cfg_tap = pwdata[TW-1:0];
        priority if (w_cfg_tap == '0) begin
            w_cfg_tap = TW'(1);
        end else if (int'(w_cfg_tap) > MAX_TAPS) begin
            w_cfg_tap = TAP_MAX;
        end
    end

    assign prdata = (paddr[PW-1:2] == firch_pkg::REG_TAP_COUNT)
                    ? firch_pkg::APB_DW'(r_tap) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap       <= TAP_RST;
            r_pos       <= '0;
            r_hvalid    <= '0;
            r_cvalid    <= '0;
            r_s1        <= 1'b0;
            r_s2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1 <= w_rd_en;
            r_s2 <= r_s1;
            if (w_cfg_we) begin
                r_tap    <= w_cfg_tap;
                r_pos    <= '0;
                r_hvalid <= '0;
            end else if (w_smp_acc) begin
                r_hvalid[r_pos] <= 1'b1;
                if ((CW'(r_pos) + CW'(1)) == CW'(r_tap)) begin
                    r_pos <= '0;
                end else begin
                    r_pos <= r_pos + AW'(1);
                end
            end
            if (w_coef_we) begin
                r_cvalid[AW'(i_in_data.tap_index)] <= 1'b1;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_smp_acc) begin
            r_k <= '0;
            r_h <= r_pos;
        end else if (w_rd_en) begin
            r_k <= r_k + AW'(1);
            // step back through the ring, wrapping below zero
            if (r_h == '0) begin
                r_h <= AW'(w_tap_m1);
            end else begin
                r_h <= r_h - AW'(1);
            end
        end
        r_hv1 <= r_hvalid[r_h];
        r_cv1 <= r_cvalid[r_k];
        if (w_load) begin
            r_out.filtered_sample <= w_q;
            r_out.saturated       <= w_sat;
        end
    end

    firch_ram #(
        .WIDTH (SB),
        .DEPTH (MAX_TAPS),
        .AW    (AW)
    ) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (w_smp_acc),
        .i_waddr (r_pos),
        .i_wdata (i_in_data.value),
        .i_raddr (r_h),
        .o_rdata (w_hist_q)
    );

    firch_ram #(
        .WIDTH (SB),
        .DEPTH (MAX_TAPS),
        .AW    (AW)
    ) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (w_coef_we),
        .i_waddr (AW'(i_in_data.tap_index)),
        .i_wdata (i_in_data.value),
        .i_raddr (r_k),
        .o_rdata (w_coef_q)
    );

    // entries never written since reset or clear read as zero
    assign w_samp = r_hv1 ? w_hist_q : '0;
    assign w_coef = r_cv1 ? w_coef_q : '0;

    assign w_ctl.acc_clr = w_smp_acc;
    assign w_ctl.mul_en  = r_s1;
    assign w_ctl.acc_en  = r_s2;

    firch_mac #(
        .ACC_W (ACC_W)
    ) u_mac (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl),
        .i_coef (w_coef),
        .i_samp (w_samp),
        .o_q    (w_q),
        .o_sat  (w_sat)
    );

    assign o_in_stall  = (r_state != firch_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// File: rtl/firch_ram.sv
// Generic single-write, single-read RAM with registered read data.
module firch_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/firch_mac.sv
// Shared multiply-accumulate unit with round-half-up and Q1.15 saturation.
module firch_mac #(
    parameter int ACC_W = 38
) (
    input  logic                                     i_clk,
    input  firch_pkg::t_mac_ctl                      i_ctl,
    input  logic signed [firch_pkg::SAMPLE_BITS-1:0] i_coef,
    input  logic signed [firch_pkg::SAMPLE_BITS-1:0] i_samp,
    output logic signed [firch_pkg::SAMPLE_BITS-1:0] o_q,
    output logic                                     o_sat
);

    localparam int SB = firch_pkg::SAMPLE_BITS;
    localparam int FB = firch_pkg::FRAC_BITS;

    localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(64'd1 << (FB - 1));
    localparam logic signed [ACC_W-1:0] Q_MAX    = ACC_W'((64'd1 << (SB - 1)) - 64'd1);
    localparam logic signed [ACC_W-1:0] Q_MIN    = -Q_MAX - ACC_W'(1);

    logic signed [2*SB-1:0]  r_prod;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [ACC_W-1:0] w_rnd;
    logic signed [ACC_W-1:0] w_q;

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= i_coef * i_samp;
        end
        if (i_ctl.acc_clr) begin
            r_acc <= '0;
        end else if (i_ctl.acc_en) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    // floor((acc + half LSB) / 2^FB)
    assign w_rnd = r_acc + RND_HALF;
    assign w_q   = w_rnd >>> FB;

    always_comb begin
        priority if (w_q > Q_MAX) begin
            o_q   = Q_MAX[SB-1:0];
            o_sat = 1'b1;
        end else if (w_q < Q_MIN) begin
            o_q   = Q_MIN[SB-1:0];
            o_sat = 1'b1;
        end else begin
            o_q   = w_q[SB-1:0];
            o_sat = 1'b0;
        end
    end

endmodule

// File: dv/firch_result_compare.sv
// Result predictor and comparator for the circular-history FIR filter testbench.
module firch_result_compare #(
    parameter int MAX_TAPS = firch_pkg::MAX_TAPS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              i_in_stall,
    input  firch_pkg::t_in_item               i_in_data,
    input  logic                              i_out_valid,
    input  logic                              i_out_stall,
    input  firch_pkg::t_out_item              i_out_data,
    input  logic                              i_psel,
    input  logic                              i_penable,
    input  logic                              i_pwrite,
    input  logic [firch_pkg::PADDR_W-1:0]     i_paddr,
    input  logic [firch_pkg::APB_DW-1:0]      i_pwdata,
    input  logic                              i_pready,
    output int                                o_mismatches,
    output int                                o_outstanding
);

    localparam int     SB         = firch_pkg::SAMPLE_BITS;
    localparam int     FB         = firch_pkg::FRAC_BITS;
    localparam longint HALF_LSB   = longint'(1) <<< (FB - 1);
    localparam longint SAMPLE_TOP = (longint'(1) <<< FB) - 1;
    localparam longint SAMPLE_BOT = -SAMPLE_TOP - 1;

    logic signed [SB-1:0]          sample_ring [MAX_TAPS];
    logic signed [SB-1:0]          tap_coefs   [MAX_TAPS];
    int unsigned                   ring_pos;
    int unsigned                   taps_in_use;
    firch_pkg::t_out_item          pending_filtered [$];
    firch_pkg::t_out_item          oldest;

    initial o_mismatches  = 0;
    initial o_outstanding = 0;

    task automatic report_mismatch(input string what, input int got, input int want_v);
        $display("%0t: %s: got %0d, expected %0d", $time, what, got, want_v);
        o_mismatches++;
    endtask

    task automatic clear_history();
        foreach (sample_ring[i]) sample_ring[i] = '0;
        ring_pos = 0;
    endtask

    // Shift the sample into the ring, run the dot product, round half up, clip.
    function automatic firch_pkg::t_out_item filter_sample(
            input logic signed [SB-1:0] x);
        firch_pkg::t_out_item r;
        longint      acc;
        longint      q;
        int unsigned n;
        int unsigned pos;
        int unsigned h;
        int unsigned k;
        n = taps_in_use;
        pos = (ring_pos >= n) ? 0 : ring_pos;
        sample_ring[pos] = x;
        acc = 0;
        for (k = 0; k < n; k++) begin
            h = (pos + n - k) % n;
            acc += longint'(tap_coefs[k]) * longint'(sample_ring[h]);
        end
        q = (acc + HALF_LSB) >>> FB;
        r.saturated = 1'b0;
        if (q > SAMPLE_TOP) begin
            q = SAMPLE_TOP;
            r.saturated = 1'b1;
        end else if (q < SAMPLE_BOT) begin
            q = SAMPLE_BOT;
            r.saturated = 1'b1;
        end
        r.filtered_sample = q[SB-1:0];
        ring_pos = (pos + 1) % n;
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_history();
            foreach (tap_coefs[i]) tap_coefs[i] = '0;
            taps_in_use = (MAX_TAPS < 64) ? MAX_TAPS : 64;
            pending_filtered.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (pending_filtered.size() == 0) begin
                    report_mismatch("result with nothing pending",
                                    int'(i_out_data.filtered_sample), 0);
                end else begin
                    oldest = pending_filtered.pop_front();
                    if (i_out_data.filtered_sample !== oldest.filtered_sample)
                        report_mismatch("filtered_sample", int'(i_out_data.filtered_sample),
                                        int'(oldest.filtered_sample));
                    if (i_out_data.saturated !== oldest.saturated)
                        report_mismatch("saturated", int'(i_out_data.saturated),
                                        int'(oldest.saturated));
                end
            end
            if (i_psel && i_penable && i_pwrite && i_pready
                    && i_paddr[firch_pkg::PADDR_W-1:2] == firch_pkg::REG_TAP_COUNT) begin
                // Clamp the tap count and drop the history.
                taps_in_use = 32'(i_pwdata[firch_pkg::TAP_W-1:0]);
                if (taps_in_use < 1) taps_in_use = 1;
                if (taps_in_use > MAX_TAPS) taps_in_use = MAX_TAPS;
                clear_history();
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_in_data.opcode == firch_pkg::OP_COEF) begin
                    if (i_in_data.tap_index < MAX_TAPS)
                        tap_coefs[i_in_data.tap_index] = i_in_data.value;
                end else begin
                    pending_filtered.push_back(filter_sample(i_in_data.value));
                end
            end
        end
        o_outstanding = pending_filtered.size();
    end

endmodule

// File: dv/tb_fir_filter_circular_history_core.sv
// Testbench top for the circular-history FIR filter: stimulus, receiver and verdict.
module tb_fir_filter_circular_history_core;

    localparam int PHASE_ITEMS  = 75;
    localparam int DRAIN_CYCLES = 80;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 3000;
    localparam int IDLE_PCT     = 30;
    localparam int PW           = firch_pkg::PADDR_W;
    localparam int DW           = firch_pkg::APB_DW;
    localparam int SB           = firch_pkg::SAMPLE_BITS;
    localparam int IW           = firch_pkg::IDX_W;
    localparam int TW           = firch_pkg::TAP_W;
    localparam logic [PW-1:0] TAP_COUNT_ADDR = {firch_pkg::REG_TAP_COUNT, 2'b00};

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    firch_pkg::t_in_item  in_data   = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    firch_pkg::t_out_item out_data;
    logic                 psel      = 1'b0;
    logic                 penable   = 1'b0;
    logic                 pwrite    = 1'b0;
    logic [PW-1:0]        paddr     = '0;
    logic [DW-1:0]        pwdata    = '0;
    logic [DW-1:0]        prdata;
    logic                 pready;
    int                   mismatches;
    int                   outstanding;

    logic                calm      = 1'b0;
    logic                long_hold = 1'b0;
    logic                hold_done = 1'b0;
    int                  hold_count = 0;

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    fir_filter_circular_history_core i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    firch_result_compare i_compare (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_in_data     (in_data),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_out_data    (out_data),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .i_pready      (pready),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    // Receiver: one long hold-off when asked, otherwise random stalls.
    always @(posedge clk) begin
        if (long_hold && !hold_done) begin
            out_stall <= 1'b1;
            hold_count++;
            if (hold_count >= HOLD_CYCLES) hold_done = 1'b1;
        end else if (calm) begin
            out_stall <= 1'b0;
        end else begin
            out_stall <= ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // End the run when nothing moves for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        forever begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall)
                    || (psel && penable && pready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT) begin
                $display("timeout: no transfer in %0d cycles", STALL_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    function automatic logic signed [SB-1:0] pick_value();
        case ($urandom_range(0, 3))
            0: begin
                case ($urandom_range(0, 4))
                    0: pick_value = 16'sh7FFF;
                    1: pick_value = 16'sh8000;
                    2: pick_value = 16'sh0000;
                    3: pick_value = 16'sh0001;
                    default: pick_value = 16'shFFFF;
                endcase
            end
            1: pick_value = 16'(int'($urandom_range(0, 511)) - 256);
            default: pick_value = 16'($urandom);
        endcase
    endfunction

    // Offer one request and hold it until accepted; ends on the accepting edge.
    task automatic send_request(input firch_pkg::t_opcode op, input logic [IW-1:0] idx,
                                input logic signed [SB-1:0] v);
        logic taken;
        if (!calm) begin
            while ($urandom_range(0, 99) < IDLE_PCT) begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid          <= 1'b1;
        in_data.opcode    <= op;
        in_data.tap_index <= idx;
        in_data.value     <= v;
        do begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end while (!taken);
    endtask

    // Wait for every pending result, then let the block settle.
    task automatic drain();
        in_valid <= 1'b0;
        while (outstanding != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_tap_count(input logic [TW-1:0] taps);
        logic [DW-1:0] wdata;
        logic          done;
        wdata = $urandom;
        wdata[TW-1:0] = taps;
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= TAP_COUNT_ADDR;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do begin
            @(negedge clk);
            done = pready;
            @(posedge clk);
        end while (!done);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic random_phase(input logic [TW-1:0] taps);
        int eff;
        int n;
        logic [IW-1:0] idx;
        eff = (taps == 0) ? 1
            : (taps > firch_pkg::MAX_TAPS_DEF) ? firch_pkg::MAX_TAPS_DEF : int'(taps);
        write_tap_count(taps);
        for (n = 0; n < PHASE_ITEMS; n++) begin
            idx = ($urandom_range(0, 3) == 0) ? IW'($urandom)
                                              : IW'($urandom_range(0, eff - 1));
            if ($urandom_range(0, 99) < 20)
                send_request(firch_pkg::OP_COEF, idx, pick_value());
            else
                send_request(firch_pkg::OP_FILTER, IW'($urandom), pick_value());
        end
        drain();
    endtask

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset tap count, extreme slots and values.
        send_request(firch_pkg::OP_COEF, 6'd63, 16'sh8000);
        send_request(firch_pkg::OP_COEF, 6'd0, 16'sh7FFF);
        send_request(firch_pkg::OP_FILTER, 6'd63, 16'sh7FFF);
        send_request(firch_pkg::OP_FILTER, 6'd0, 16'sh8000);
        send_request(firch_pkg::OP_FILTER, 6'd21, 16'sh0000);
        drain();

        // Zero tap count acts as one tap: rounding ties and clipping.
        write_tap_count(7'd0);
        send_request(firch_pkg::OP_COEF, 6'd0, 16'sh4000);
        send_request(firch_pkg::OP_FILTER, 6'd42, 16'sh0001);
        send_request(firch_pkg::OP_FILTER, 6'd0, 16'shFFFF);
        send_request(firch_pkg::OP_FILTER, 6'd0, 16'sh0003);
        send_request(firch_pkg::OP_FILTER, 6'd0, 16'shFFFD);
        send_request(firch_pkg::OP_COEF, 6'd0, 16'sh8000);
        send_request(firch_pkg::OP_FILTER, 6'd0, 16'sh8000);
        send_request(firch_pkg::OP_FILTER, 6'd0, 16'sh7FFF);
        send_request(firch_pkg::OP_COEF, 6'd0, 16'sh7FFF);
        send_request(firch_pkg::OP_FILTER, 6'd0, 16'sh7FFF);
        send_request(firch_pkg::OP_FILTER, 6'd0, 16'sh8000);
        // Store slots outside the active taps; they count once the taps grow.
        send_request(firch_pkg::OP_COEF, 6'd62, 16'sh7FFF);
        send_request(firch_pkg::OP_COEF, 6'd1, 16'sh7FFF);
        drain();

        // Oversized tap count clamps to the maximum.
        write_tap_count(7'd127);
        send_request(firch_pkg::OP_FILTER, 6'd0, 16'sh7FFF);
        send_request(firch_pkg::OP_FILTER, 6'd0, 16'sh7FFF);
        send_request(firch_pkg::OP_FILTER, 6'd0, 16'sh8000);
        drain();

        // Fill the block while the receiver holds off.
        long_hold <= 1'b1;
        random_phase(7'd2);
        random_phase(7'd64);
        calm <= 1'b1;
        random_phase(7'($urandom_range(3, 16)));
        calm <= 1'b0;
        random_phase(7'd1);
        random_phase(7'd100);
        random_phase(7'($urandom_range(17, 63)));
        random_phase(7'($urandom_range(2, 8)));

        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
